// ===== hdl/spg_pkg.sv =====
`timescale 1ns / 1ps

package spg_pkg;

    localparam int DATA_W = 32;
    localparam int NS_W   = 30;
    localparam int OP_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] NS_PER_S = 32'd1000000000;
    localparam logic [DATA_W-1:0] TIMER_HZ = 32'd24000000;

    // operation codes of an input beat
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_ENABLE = 2'd2;
    localparam logic [OP_W-1:0] OP_SETUP  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_INV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_NS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_NS  = 2'd3;

    // internal direction sequencing
    localparam logic [1:0] DIRW_NONE  = 2'd0;
    localparam logic [1:0] DIRW_HOLD  = 2'd1;
    localparam logic [1:0] DIRW_SETUP = 2'd2;

    // reported phase
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SETUP = 2'd1;
    localparam logic [1:0] PH_HOLD  = 2'd2;
    localparam logic [1:0] PH_STEP  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    // saturate a nanosecond value to 1 .. 1e9
    function automatic logic [DATA_W-1:0] clamp_ns(input logic [NS_W-1:0] ns);
        logic [DATA_W-1:0] wide;
        wide = {{(DATA_W-NS_W){1'b0}}, ns};
        if (wide == '0) begin
            return {{(DATA_W-1){1'b0}}, 1'b1};
        end else if (wide > NS_PER_S) begin
            return NS_PER_S;
        end else begin
            return wide;
        end
    endfunction

endpackage

// ===== hdl/spg_div.sv =====
`timescale 1ns / 1ps

module spg_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  spg_pkg::div_req_t req,
    output spg_pkg::div_rsp_t rsp
);
    import spg_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic              fits;

    // one restoring step per cycle, remainder stays below the divisor
    always_comb begin
        shifted  = {rem_reg, quo_reg[DATA_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        fits     = !diff[DATA_W+1];
        rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_next = {quo_reg[DATA_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/step_dir_pulse_generator.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    operation, step_count, direction, move_time_ns,
//                                           enable_value
// m_        out        m_valid / m_ready    step_pin, dir_pin, busy_res, steps_left, phase
// cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// load and enable beats go straight to ST_RESP; a tick that starts no task
// passes ST_TICK and ST_BODY. each division runs on the shared radix-2 divider.
// a tick that starts a task: 3 divisions, after ST_SUB1/ST_SUB2 if the direction changes.
// channel setup: 4 divisions.
// s_ready is high only while the sequencer is idle; a held result in the output
// register does not block the next input beat. synchronous active-low reset.

module step_dir_pulse_generator #(
    parameter logic [spg_pkg::DATA_W-1:0] TIMER_HZ = spg_pkg::TIMER_HZ
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [spg_pkg::OP_W-1:0]         s_operation,
    input  logic [spg_pkg::DATA_W-1:0]       s_step_count,
    input  logic                             s_direction,
    input  logic [spg_pkg::NS_W-1:0]         s_move_time_ns,
    input  logic                             s_enable_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_step_pin,
    output logic                             m_dir_pin,
    output logic                             m_busy_res,
    output logic [spg_pkg::DATA_W-1:0]       m_steps_left,
    output logic [1:0]                       m_phase,
    input  logic                             cfg_we,
    input  logic [spg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spg_pkg::NS_W-1:0]         cfg_wdata
);
    import spg_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TICK = 4'd1;
    localparam logic [3:0] ST_SUB1 = 4'd2;
    localparam logic [3:0] ST_SUB2 = 4'd3;
    localparam logic [3:0] ST_DIV1 = 4'd4;
    localparam logic [3:0] ST_DIV2 = 4'd5;
    localparam logic [3:0] ST_DIV3 = 4'd6;
    localparam logic [3:0] ST_BODY = 4'd7;
    localparam logic [3:0] ST_CFG1 = 4'd8;
    localparam logic [3:0] ST_CFG2 = 4'd9;
    localparam logic [3:0] ST_CFG3 = 4'd10;
    localparam logic [3:0] ST_CFG4 = 4'd11;
    localparam logic [3:0] ST_RESP = 4'd12;

    // configuration
    logic            step_inv_reg, dir_inv_reg;
    logic [NS_W-1:0] setup_ns_reg, hold_ns_reg;

    // channel state
    logic [DATA_W-1:0] now_reg, deadline_reg, half_reg;
    logic [DATA_W-1:0] setup_ticks_reg, hold_ticks_reg, remaining_reg;
    logic              step_level_reg, dir_level_reg, target_dir_reg;
    logic [1:0]        dir_phase_reg;
    logic              active_reg, enabled_reg;
    logic              pend_flag_reg, pend_dir_reg;
    logic [DATA_W-1:0] pend_steps_reg;
    logic [NS_W-1:0]   pend_time_reg;

    // sequencer
    logic [3:0]               state_reg;
    logic                     div_run_reg;
    logic [DATA_W-1:0]        q_reg;
    logic signed [DATA_W-1:0] t_reg;
    logic                     m_valid_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                     is_div_state;
    logic [DATA_W-1:0]        lag;
    logic                     due;
    logic [DATA_W-1:0]        sub_val;
    logic signed [DATA_W-1:0] t_sub;
    logic                     in_beat;
    logic                     out_free;
    logic                     start_ok;
    logic                     stop_ok;

    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // wrap-safe compare: due when now - deadline is not negative
    assign lag = now_reg - deadline_reg;
    assign due = !lag[DATA_W-1];

    assign stop_ok  = !step_level_reg && !enabled_reg && active_reg;
    assign start_ok = !step_level_reg && enabled_reg && pend_flag_reg;

    // shared subtractor for taking the direction delays off the move time
    assign sub_val = (state_reg == ST_SUB1) ? clamp_ns(setup_ns_reg) : clamp_ns(hold_ns_reg);
    assign t_sub   = t_reg - $signed(sub_val);

    always_comb begin
        is_div_state     = 1'b1;
        div_req.dividend = TIMER_HZ;
        div_req.divisor  = q_reg;
        case (state_reg)
            ST_DIV1: begin
                div_req.dividend = NS_PER_S;
                div_req.divisor  = DATA_W'(unsigned'(t_reg));
            end
            ST_DIV2, ST_CFG2, ST_CFG4: begin
                div_req.dividend = TIMER_HZ;
                div_req.divisor  = q_reg;
            end
            ST_DIV3: begin
                div_req.dividend = q_reg;
                div_req.divisor  = remaining_reg;
            end
            ST_CFG1: begin
                div_req.dividend = NS_PER_S;
                div_req.divisor  = clamp_ns(setup_ns_reg);
            end
            ST_CFG3: begin
                div_req.dividend = NS_PER_S;
                div_req.divisor  = clamp_ns(hold_ns_reg);
            end
            default: begin
                is_div_state = 1'b0;
            end
        endcase
        div_req.start = is_div_state && !div_run_reg && !div_rsp.done;
    end

    spg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_inv_reg <= 1'b0;
            dir_inv_reg  <= 1'b0;
            setup_ns_reg <= NS_W'(1000);
            hold_ns_reg  <= NS_W'(1000);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_STEP_INV: step_inv_reg <= cfg_wdata[0];
                CFG_DIR_INV:  dir_inv_reg  <= cfg_wdata[0];
                CFG_SETUP_NS: setup_ns_reg <= cfg_wdata;
                CFG_HOLD_NS:  hold_ns_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg         <= '0;
            deadline_reg    <= '0;
            half_reg        <= '0;
            setup_ticks_reg <= '0;
            hold_ticks_reg  <= '0;
            remaining_reg   <= '0;
            step_level_reg  <= 1'b0;
            dir_level_reg   <= 1'b0;
            target_dir_reg  <= 1'b0;
            dir_phase_reg   <= DIRW_NONE;
            active_reg      <= 1'b0;
            enabled_reg     <= 1'b0;
            pend_flag_reg   <= 1'b0;
            pend_steps_reg  <= '0;
            pend_dir_reg    <= 1'b0;
            pend_time_reg   <= '0;
            state_reg       <= ST_IDLE;
            div_run_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // in ST_RESP the output register is refilled instead
            if (m_valid_reg && m_ready && state_reg != ST_RESP) begin
                m_valid_reg <= 1'b0;
            end
            if (div_req.start) begin
                div_run_reg <= 1'b1;
            end else if (div_rsp.done) begin
                div_run_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        case (s_operation)
                            OP_TICK: begin
                                now_reg   <= now_reg + 1'b1;
                                state_reg <= ST_TICK;
                            end
                            OP_LOAD: begin
                                pend_steps_reg <= s_step_count;
                                pend_dir_reg   <= s_direction;
                                pend_time_reg  <= s_move_time_ns;
                                pend_flag_reg  <= 1'b1;
                                state_reg      <= ST_RESP;
                            end
                            OP_ENABLE: begin
                                enabled_reg <= s_enable_value;
                                state_reg   <= ST_RESP;
                            end
                            OP_SETUP: begin
                                active_reg     <= 1'b0;
                                remaining_reg  <= '0;
                                dir_phase_reg  <= DIRW_NONE;
                                step_level_reg <= 1'b0;
                                dir_level_reg  <= 1'b0;
                                state_reg      <= ST_CFG1;
                            end
                            default: state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_TICK: begin
                    state_reg <= ST_BODY;
                    if (stop_ok) begin
                        active_reg <= 1'b0;
                    end else if (start_ok) begin
                        pend_flag_reg <= 1'b0;
                        remaining_reg <= pend_steps_reg;
                        if (pend_steps_reg == '0) begin
                            // empty task is consumed and the channel stays idle
                            active_reg <= 1'b0;
                        end else begin
                            active_reg <= 1'b1;
                            if (dir_level_reg == pend_dir_reg) begin
                                dir_phase_reg <= DIRW_NONE;
                                deadline_reg  <= now_reg;
                                state_reg     <= ST_DIV1;
                            end else begin
                                target_dir_reg <= pend_dir_reg;
                                dir_phase_reg  <= DIRW_SETUP;
                                deadline_reg   <= now_reg + setup_ticks_reg;
                                state_reg      <= ST_SUB1;
                            end
                        end
                    end
                end
                ST_SUB1: begin
                    state_reg <= ST_SUB2;
                end
                ST_SUB2: begin
                    state_reg <= ST_DIV1;
                end
                ST_DIV1: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_DIV3;
                    end
                end
                ST_DIV3: begin
                    if (div_rsp.done) begin
                        half_reg  <= {1'b0, div_rsp.quotient[DATA_W-1:1]};
                        state_reg <= ST_BODY;
                    end
                end
                ST_BODY: begin
                    state_reg <= ST_RESP;
                    if (active_reg) begin
                        if (dir_phase_reg != DIRW_NONE) begin
                            if (due) begin
                                if (dir_phase_reg == DIRW_SETUP) begin
                                    dir_level_reg <= target_dir_reg;
                                    deadline_reg  <= deadline_reg + hold_ticks_reg;
                                end else if (remaining_reg != '0) begin
                                    deadline_reg <= now_reg;
                                end
                                dir_phase_reg <= dir_phase_reg - 1'b1;
                            end
                        end else if (remaining_reg == '0) begin
                            active_reg <= 1'b0;
                        end else if (due) begin
                            // a falling edge completes one step
                            if (step_level_reg) begin
                                step_level_reg <= 1'b0;
                                remaining_reg  <= remaining_reg - 1'b1;
                            end else begin
                                step_level_reg <= 1'b1;
                            end
                            deadline_reg <= deadline_reg + half_reg;
                        end
                    end
                end
                ST_CFG1: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_CFG2;
                    end
                end
                ST_CFG2: begin
                    if (div_rsp.done) begin
                        setup_ticks_reg <= div_rsp.quotient;
                        state_reg       <= ST_CFG3;
                    end
                end
                ST_CFG3: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_CFG4;
                    end
                end
                ST_CFG4: begin
                    if (div_rsp.done) begin
                        hold_ticks_reg <= div_rsp.quotient;
                        state_reg      <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_TICK) begin
            t_reg <= $signed(clamp_ns(pend_time_reg));
        end else if (state_reg == ST_SUB1) begin
            t_reg <= t_sub;
        end else if (state_reg == ST_SUB2) begin
            // too short for the delays: use one nanosecond
            if (t_sub[DATA_W-1] || t_sub == '0) begin
                t_reg <= DATA_W'(1);
            end else begin
                t_reg <= t_sub;
            end
        end
        if (div_rsp.done) begin
            q_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_RESP && out_free) begin
            m_step_pin   <= step_level_reg ^ step_inv_reg;
            m_dir_pin    <= dir_level_reg ^ dir_inv_reg;
            m_busy_res   <= active_reg;
            m_steps_left <= remaining_reg;
            if (!active_reg) begin
                m_phase <= PH_IDLE;
            end else if (dir_phase_reg == DIRW_SETUP) begin
                m_phase <= PH_SETUP;
            end else if (dir_phase_reg == DIRW_HOLD) begin
                m_phase <= PH_HOLD;
            end else begin
                m_phase <= PH_STEP;
            end
        end
    end

endmodule

// ===== hdl/spg_checker.sv =====
`timescale 1ns / 1ps

module spg_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_step_pin,
    input logic                             m_dir_pin,
    input logic                             m_busy_res,
    input logic [spg_pkg::DATA_W-1:0]       m_steps_left,
    input logic [1:0]                       m_phase
);
    import spg_pkg::*;

    // a stalled result beat holds
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_step_pin) && $stable(m_dir_pin)
            && $stable(m_busy_res) && $stable(m_steps_left) && $stable(m_phase))
        else $error("result beat changed while stalled");

    a_busy_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_busy_res == (m_phase != PH_IDLE)))
        else $error("busy flag disagrees with phase");

    // direction work only happens for a task with steps to make
    a_dir_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_phase == PH_SETUP || m_phase == PH_HOLD) |-> m_steps_left != '0)
        else $error("direction phase with no steps left");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind step_dir_pulse_generator spg_checker u_spg_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import spg_pkg::*;

    typedef struct {
        logic              step_pin;
        logic              dir_pin;
        logic              busy;
        logic [DATA_W-1:0] steps_left;
        logic [1:0]        phase;
    } pin_state_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_operation = OP_TICK;
    logic [DATA_W-1:0] s_step_count = '0;
    logic              s_direction = 1'b0;
    logic [NS_W-1:0]   s_move_time_ns = '0;
    logic              s_enable_value = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_step_pin;
    logic              m_dir_pin;
    logic              m_busy_res;
    logic [DATA_W-1:0] m_steps_left;
    logic [1:0]        m_phase;
    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_STEP_INV;
    logic [NS_W-1:0]   cfg_wdata = '0;

    // channel state as the predictor sees it
    logic [DATA_W-1:0] tick_count = '0;
    logic [DATA_W-1:0] due_at = '0;
    logic [DATA_W-1:0] half_ticks = '0;
    logic [DATA_W-1:0] setup_len = '0;
    logic [DATA_W-1:0] hold_len = '0;
    logic [DATA_W-1:0] steps_to_go = '0;
    logic              step_lvl = 1'b0;
    logic              dir_lvl = 1'b0;
    logic              dir_goal = 1'b0;
    logic [1:0]        dir_seq = DIRW_NONE;
    logic              running = 1'b0;
    logic              chan_en = 1'b0;
    logic              queued = 1'b0;
    logic [DATA_W-1:0] q_steps = '0;
    logic              q_dir = 1'b0;
    logic [NS_W-1:0]   q_time = '0;

    // register copies
    logic              inv_step = 1'b0;
    logic              inv_dir = 1'b0;
    logic [NS_W-1:0]   setup_ns = NS_W'(1000);
    logic [NS_W-1:0]   hold_ns = NS_W'(1000);

    pin_state_t pin_state_q[$];
    int         err_count = 0;
    int         beats_sent = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    step_dir_pulse_generator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_step_count   (s_step_count),
        .s_direction    (s_direction),
        .s_move_time_ns (s_move_time_ns),
        .s_enable_value (s_enable_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step_pin     (m_step_pin),
        .m_dir_pin      (m_dir_pin),
        .m_busy_res     (m_busy_res),
        .m_steps_left   (m_steps_left),
        .m_phase        (m_phase),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [DATA_W-1:0] sat_ns(input logic [NS_W-1:0] ns);
        logic [DATA_W-1:0] v;
        v = DATA_W'(ns);
        if (v == 0) begin
            return 1;
        end
        return (v > NS_PER_S) ? NS_PER_S : v;
    endfunction

    function automatic logic [DATA_W-1:0] to_ticks(input logic [NS_W-1:0] ns);
        return TIMER_HZ / (NS_PER_S / sat_ns(ns));
    endfunction

    // wrap-safe: due once the signed distance to the deadline is not negative
    function automatic logic deadline_hit();
        logic [DATA_W-1:0] gap;
        gap = tick_count - due_at;
        return !gap[DATA_W-1];
    endfunction

    task automatic begin_move();
        logic [DATA_W-1:0]   t;
        logic signed [63:0] trimmed;
        t = sat_ns(q_time);
        queued = 1'b0;
        steps_to_go = q_steps;
        if (steps_to_go == 0) begin
            running = 1'b0;
        end else begin
            running = 1'b1;
            if (dir_lvl == q_dir) begin
                dir_seq = DIRW_NONE;
                due_at = tick_count;
            end else begin
                // direction change eats the setup and hold time out of the move
                trimmed = $signed({32'b0, t}) - $signed({32'b0, sat_ns(setup_ns)})
                          - $signed({32'b0, sat_ns(hold_ns)});
                t = (trimmed < 1) ? 32'd1 : trimmed[31:0];
                dir_goal = q_dir;
                dir_seq = DIRW_SETUP;
                due_at = tick_count + setup_len;
            end
            half_ticks = TIMER_HZ / (NS_PER_S / t) / steps_to_go / 2;
        end
    endtask

    task automatic advance_channel();
        if (!step_lvl) begin
            if (!chan_en && running) begin
                running = 1'b0;
            end else if (queued && chan_en) begin
                begin_move();
            end
        end
        if (running) begin
            if (dir_seq != DIRW_NONE) begin
                if (deadline_hit()) begin
                    if (dir_seq == DIRW_SETUP) begin
                        dir_lvl = dir_goal;
                        due_at = due_at + hold_len;
                    end else if (steps_to_go != 0) begin
                        due_at = tick_count;
                    end
                    dir_seq = dir_seq - 2'd1;
                end
            end else if (steps_to_go == 0) begin
                running = 1'b0;
            end else if (deadline_hit()) begin
                if (step_lvl) begin
                    step_lvl = 1'b0;
                    steps_to_go = steps_to_go - 1;
                end else begin
                    step_lvl = 1'b1;
                end
                due_at = due_at + half_ticks;
            end
        end
    endtask

    task automatic apply_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] cnt,
                              input logic dir, input logic [NS_W-1:0] tm, input logic en);
        pin_state_t p;
        case (op)
            OP_TICK: begin
                tick_count = tick_count + 1;
                advance_channel();
            end
            OP_LOAD: begin
                q_steps = cnt;
                q_dir = dir;
                q_time = tm;
                queued = 1'b1;
            end
            OP_ENABLE: begin
                chan_en = en;
            end
            default: begin
                running = 1'b0;
                steps_to_go = '0;
                dir_seq = DIRW_NONE;
                step_lvl = 1'b0;
                dir_lvl = 1'b0;
                setup_len = to_ticks(setup_ns);
                hold_len = to_ticks(hold_ns);
            end
        endcase
        p.step_pin = step_lvl ^ inv_step;
        p.dir_pin = dir_lvl ^ inv_dir;
        p.busy = running;
        p.steps_left = steps_to_go;
        if (!running) begin
            p.phase = PH_IDLE;
        end else if (dir_seq == DIRW_SETUP) begin
            p.phase = PH_SETUP;
        end else if (dir_seq == DIRW_HOLD) begin
            p.phase = PH_HOLD;
        end else begin
            p.phase = PH_STEP;
        end
        pin_state_q.push_back(p);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        pin_state_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pin_state_q.size() == 0) begin
                $error("result beat with no expected result pending");
                err_count++;
            end else begin
                want = pin_state_q.pop_front();
                check_field("step_pin", want.step_pin, m_step_pin);
                check_field("dir_pin", want.dir_pin, m_dir_pin);
                check_field("busy_res", want.busy, m_busy_res);
                check_field("steps_left", want.steps_left, m_steps_left);
                check_field("phase", want.phase, m_phase);
            end
        end
    end

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] cnt,
                             input logic dir, input logic [NS_W-1:0] tm, input logic en);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_step_count <= cnt;
        s_direction <= dir;
        s_move_time_ns <= tm;
        s_enable_value <= en;
        do @(posedge aclk); while (!s_ready);
        apply_beat(op, cnt, dir, tm, en);
        beats_sent++;
    endtask

    // unused fields carry random junk
    task automatic send_op(input logic [OP_W-1:0] op);
        send_beat(op, $urandom, 1'($urandom_range(1)), NS_W'($urandom),
                  1'($urandom_range(1)));
    endtask

    task automatic send_load(input logic [DATA_W-1:0] cnt, input logic dir,
                             input logic [NS_W-1:0] tm);
        send_beat(OP_LOAD, cnt, dir, tm, 1'($urandom_range(1)));
    endtask

    task automatic send_enable(input logic en);
        send_beat(OP_ENABLE, $urandom, 1'($urandom_range(1)), NS_W'($urandom), en);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pin_state_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_regs(input logic si, input logic di, input logic [NS_W-1:0] su,
                            input logic [NS_W-1:0] ho);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STEP_INV;
        cfg_wdata <= NS_W'(si);
        @(posedge aclk);
        cfg_index <= CFG_DIR_INV;
        cfg_wdata <= NS_W'(di);
        @(posedge aclk);
        cfg_index <= CFG_SETUP_NS;
        cfg_wdata <= su;
        @(posedge aclk);
        cfg_index <= CFG_HOLD_NS;
        cfg_wdata <= ho;
        @(posedge aclk);
        cfg_we <= 1'b0;
        inv_step = si;
        inv_dir = di;
        setup_ns = su;
        hold_ns = ho;
    endtask

    function automatic logic [DATA_W-1:0] rand_steps();
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            return $urandom;
        end else if (r < 10) begin
            return 0;
        end
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [NS_W-1:0] rand_move_ns();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return NS_W'($urandom);
        end else if (r < 25) begin
            return NS_W'($urandom_range(0, 2500));
        end
        return NS_W'($urandom_range(200, 6000));
    endfunction

    task automatic run_moves(input int n);
        int first, cap, r;
        first = beats_sent;
        while (beats_sent - first < n) begin
            r = $urandom_range(99);
            if (r < 70) begin
                if (!chan_en || $urandom_range(9) == 0) begin
                    send_enable(1'b1);
                end
                if ($urandom_range(9) == 0) begin
                    send_op(OP_SETUP);
                end
                send_load(rand_steps(), 1'($urandom_range(1)), rand_move_ns());
                // tick until the move is done or the budget runs out
                cap = $urandom_range(10, 200);
                do begin
                    send_op(OP_TICK);
                    cap--;
                end while (cap > 0 && (running || (queued && chan_en)));
            end else if (r < 80) begin
                send_op(OP_W'($urandom_range(3)));
            end else if (r < 90) begin
                // pull enable in the middle of a move, then bring it back
                send_load(rand_steps(), 1'($urandom_range(1)), rand_move_ns());
                repeat ($urandom_range(1, 20)) send_op(OP_TICK);
                send_enable(1'b0);
                repeat ($urandom_range(1, 10)) send_op(OP_TICK);
                send_enable(1'b1);
            end else begin
                repeat ($urandom_range(1, 30)) send_op(OP_TICK);
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_op(OP_TICK);
        send_op(OP_SETUP);
        send_enable(1'b1);
        // zero steps finish right away without touching direction
        send_load(0, 1'b1, NS_W'(1000));
        send_op(OP_TICK);
        // zero move time, half period of zero: toggles on every tick
        send_load(2, 1'b0, '0);
        repeat (6) send_op(OP_TICK);
        // saturated move time with a direction change
        send_load(1, 1'b1, '1);
        repeat (3) send_op(OP_TICK);
        send_op(OP_SETUP);
        // move too short for the delays, then drop enable during setup
        send_load('1, 1'b1, NS_W'(1000));
        repeat (3) send_op(OP_TICK);
        send_enable(1'b0);
        repeat (2) send_op(OP_TICK);
        send_enable(1'b1);
    endtask

    task automatic test_register_sweep();
        int k;
        send_idle_pct = 24;
        recv_stall_pct = 24;
        for (k = 0; k < 5; k++) begin
            wait_drained();
            case (k)
                0: set_regs(1'b1, 1'b0, '0, '1);
                1: set_regs(1'b0, 1'b1, '1, '0);
                2: set_regs(1'b1, 1'b1, NS_W'(1), NS_W'(1));
                3: set_regs(1'b0, 1'b0, NS_W'(1000), NS_W'(1000));
                default: set_regs(1'($urandom_range(1)), 1'($urandom_range(1)),
                                  NS_W'($urandom_range(1, 5000)),
                                  NS_W'($urandom_range(1, 5000)));
            endcase
            send_op(OP_SETUP);
            run_moves(25);
        end
    endtask

    task automatic test_idle_phases();
        int k;
        for (k = 0; k < 4; k++) begin
            wait_drained();
            set_regs(1'($urandom_range(1)), 1'($urandom_range(1)),
                     NS_W'($urandom_range(100, 3000)), NS_W'($urandom_range(100, 3000)));
            send_idle_pct = (k == 1) ? 67 : (k == 3) ? 24 : 0;
            recv_stall_pct = (k == 2) ? 67 : (k == 3) ? 24 : 0;
            send_op(OP_SETUP);
            run_moves(50);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_register_sweep();
        test_idle_phases();
        wait_drained();
        repeat (200) @(posedge aclk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/spg_pkg.sv
hdl/spg_div.sv
hdl/step_dir_pulse_generator.sv
hdl/spg_checker.sv
verif/tb.sv
